// ===== rtl/dslm_pkg.sv =====
// ---------------------------------------------------------------------------
// dslm_pkg: disk seek latency model shared definitions
// Field widths, stream packing and constant-divide reciprocals.
// ---------------------------------------------------------------------------
package dslm_pkg;

    localparam int NUM_DRIVES          = 8;
    localparam int SECTORS_PER_TRACK   = 63;
    localparam int TRACKS_PER_CYLINDER = 4;

    localparam int FUNC_W  = 2;
    localparam int DRV_W   = 3;
    localparam int ADDR_W  = 24;
    localparam int PHASE_W = 3;
    localparam int CYL_W   = 17;
    localparam int SEC_W   = 6;
    localparam int TICK_W  = 14;
    localparam int ZRUN_W  = 3;
    localparam int MASK_W  = 8;
    localparam int PHASES_W = MASK_W * PHASE_W;

    localparam int CYL_STEP_DIV     = 5;
    localparam int CYL_CHANGE_COST  = 3;
    localparam int SECTORS_PER_TICK = 3;
    localparam int ZERO_RUN_LIMIT   = 3;
    localparam int TICK_MAX         = (1 << TICK_W) - 1;

    // address / (sectors * tracks) by reciprocal, exact for ADDR_W-bit inputs
    localparam int CYL_DIV      = SECTORS_PER_TRACK * TRACKS_PER_CYLINDER;
    localparam int CYL_SHIFT    = 32;
    localparam int CYL_RECIP_W  = 25;
    localparam int CYL_PROD_W   = ADDR_W + CYL_RECIP_W;
    localparam logic [CYL_RECIP_W-1:0] CYL_RECIP =
        CYL_RECIP_W'(((64'd1 << CYL_SHIFT) + 64'(CYL_DIV) - 64'd1) / 64'(CYL_DIV));

    // cylinder distance / step divisor
    localparam int DIST_SHIFT   = 20;
    localparam int DIST_RECIP_W = 18;
    localparam int DIST_PROD_W  = CYL_W + DIST_RECIP_W;
    localparam int DIST_Q_W     = 15;
    localparam logic [DIST_RECIP_W-1:0] DIST_RECIP =
        DIST_RECIP_W'(((64'd1 << DIST_SHIFT) + 64'(CYL_STEP_DIV) - 64'd1) / 64'(CYL_STEP_DIV));

    // sector gap / sectors per tick
    localparam int GAP_SHIFT    = 7;
    localparam int GAP_RECIP_W  = 6;
    localparam int GAP_PROD_W   = SEC_W + GAP_RECIP_W;
    localparam int GAP_Q_W      = GAP_PROD_W - GAP_SHIFT;
    localparam logic [GAP_RECIP_W-1:0] GAP_RECIP =
        GAP_RECIP_W'(((64'd1 << GAP_SHIFT) + 64'(SECTORS_PER_TICK) - 64'd1)
                     / 64'(SECTORS_PER_TICK));

    localparam int RAW_TICK_W = 16;

    // stream packing
    localparam int IN_DRIVE_LSB = 0;
    localparam int IN_ADDR_LSB  = IN_DRIVE_LSB + DRV_W;
    localparam int IN_PHASE_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_SPIN_LSB  = IN_PHASE_LSB + PHASE_W;
    localparam int IN_TDATA_W   = 32;

    localparam int OUT_TICKS_LSB  = 0;
    localparam int OUT_DONE_LSB   = OUT_TICKS_LSB + TICK_W;
    localparam int OUT_PHASES_LSB = OUT_DONE_LSB + MASK_W;
    localparam int OUT_BUSY_LSB   = OUT_PHASES_LSB + PHASES_W;
    localparam int OUT_USED_W     = OUT_BUSY_LSB + MASK_W;
    localparam int OUT_TDATA_W    = 56;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEEK = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_SPIN = 2'd2
    } t_func;

endpackage

// ===== rtl/disk_seek_latency_model_top.sv =====
// ---------------------------------------------------------------------------
// disk_seek_latency_model_top: seek and rotation latency model
// Per-drive seek timing, tick countdown and platter rotation for up to eight
// disks, one result per request.
// ---------------------------------------------------------------------------
// Path: a request presented with tvalid passes the input register, then the result
//   register; drive state updates with the result, in one per-drive pass.
// Throughput: one request per cycle while m_axis_tready does not stall the result.
// Reset: synchronous, active low; clears all drive state, the present mask
//   and both pipeline valids.
module disk_seek_latency_model_top #(
    parameter int NUM_DRIVES = dslm_pkg::NUM_DRIVES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: drive_present_mask
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dslm_pkg::MASK_W-1:0]      i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // drive[2:0], block_address[26:3], next_phase[29:27], spin_on[30], zero[31]
    input  logic [dslm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [dslm_pkg::FUNC_W-1:0]      s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // seek_ticks[13:0], done_mask[21:14], done_phases[45:22], busy_mask[53:46],
    // zero[55:54]
    output logic [dslm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [dslm_pkg::DRV_W:0] DRV_LIMIT = (dslm_pkg::DRV_W + 1)'(NUM_DRIVES);

    // configuration
    logic [dslm_pkg::MASK_W-1:0] r_present;

    // input register
    logic                          r_in_valid;
    logic [dslm_pkg::FUNC_W-1:0]   r_in_func;
    logic [dslm_pkg::DRV_W-1:0]    r_in_drive;
    logic [dslm_pkg::PHASE_W-1:0]  r_in_phase;
    logic                          r_in_spin;
    logic [dslm_pkg::CYL_W-1:0]    r_in_cyl;
    logic [dslm_pkg::SEC_W-1:0]    r_in_sec;

    // result register
    logic                              r_out_valid;
    logic [dslm_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic [dslm_pkg::OUT_TDATA_W-1:0]  n_out_data;

    // drive state
    logic [dslm_pkg::CYL_W-1:0]   r_head  [NUM_DRIVES];
    logic [dslm_pkg::SEC_W-1:0]   r_plat  [NUM_DRIVES];
    logic [dslm_pkg::TICK_W-1:0]  r_rem   [NUM_DRIVES];
    logic                         r_seek  [NUM_DRIVES];
    logic                         r_spin  [NUM_DRIVES];
    logic [dslm_pkg::ZRUN_W-1:0]  r_zrun  [NUM_DRIVES];
    logic [dslm_pkg::CYL_W-1:0]   r_tcyl  [NUM_DRIVES];
    logic [dslm_pkg::SEC_W-1:0]   r_tsec  [NUM_DRIVES];
    logic [dslm_pkg::PHASE_W-1:0] r_pphase[NUM_DRIVES];

    logic [dslm_pkg::CYL_W-1:0]   n_head  [NUM_DRIVES];
    logic [dslm_pkg::SEC_W-1:0]   n_plat  [NUM_DRIVES];
    logic [dslm_pkg::TICK_W-1:0]  n_rem   [NUM_DRIVES];
    logic                         n_seek  [NUM_DRIVES];
    logic                         n_spin  [NUM_DRIVES];
    logic [dslm_pkg::ZRUN_W-1:0]  n_zrun  [NUM_DRIVES];
    logic [dslm_pkg::CYL_W-1:0]   n_tcyl  [NUM_DRIVES];
    logic [dslm_pkg::SEC_W-1:0]   n_tsec  [NUM_DRIVES];
    logic [dslm_pkg::PHASE_W-1:0] n_pphase[NUM_DRIVES];

    // handshake
    logic w_advance;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // address split ahead of the input register
    logic [dslm_pkg::ADDR_W-1:0]     w_s_addr;
    logic [dslm_pkg::CYL_PROD_W-1:0] w_s_cyl_prod;
    logic [7:0]                      w_s_digsum;
    logic [6:0]                      w_s_fold;
    logic [dslm_pkg::SEC_W-1:0]      w_s_sec;

    assign w_s_addr     = s_axis_tdata[dslm_pkg::IN_ADDR_LSB +: dslm_pkg::ADDR_W];
    assign w_s_cyl_prod = dslm_pkg::CYL_PROD_W'(w_s_addr)
                        * dslm_pkg::CYL_PROD_W'(dslm_pkg::CYL_RECIP);
    // mod 63: 64 == 1 (mod 63), so sum the 6-bit digits and fold
    assign w_s_digsum = 8'(w_s_addr[5:0]) + 8'(w_s_addr[11:6])
                      + 8'(w_s_addr[17:12]) + 8'(w_s_addr[23:18]);
    assign w_s_fold   = 7'(w_s_digsum[7:6]) + 7'(w_s_digsum[5:0]);
    assign w_s_sec    = (w_s_fold >= 7'(dslm_pkg::SECTORS_PER_TRACK))
                      ? dslm_pkg::SEC_W'(w_s_fold - 7'(dslm_pkg::SECTORS_PER_TRACK))
                      : dslm_pkg::SEC_W'(w_s_fold);

    // seek latency for the addressed drive
    logic                              w_drv_ok;
    logic [dslm_pkg::CYL_W-1:0]        w_sel_head;
    logic [dslm_pkg::SEC_W-1:0]        w_sel_plat;
    logic [dslm_pkg::ZRUN_W-1:0]       w_sel_zrun;
    logic [dslm_pkg::CYL_W-1:0]        w_dist;
    logic [dslm_pkg::DIST_PROD_W-1:0]  w_dist_prod;
    logic [6:0]                        w_gap_full;
    logic [dslm_pkg::SEC_W-1:0]        w_gap;
    logic [dslm_pkg::GAP_PROD_W-1:0]   w_gap_prod;
    logic [dslm_pkg::RAW_TICK_W-1:0]   w_raw_ticks;
    logic [dslm_pkg::TICK_W-1:0]       w_sat_ticks;
    logic [6:0]                        w_zrun_sum;
    logic [dslm_pkg::TICK_W-1:0]       w_ticks;
    logic [dslm_pkg::ZRUN_W-1:0]       w_zrun_next;

    assign w_drv_ok = {1'b0, r_in_drive} < DRV_LIMIT;

    always_comb begin
        w_sel_head = '0;
        w_sel_plat = '0;
        w_sel_zrun = '0;
        for (int d = 0; d < NUM_DRIVES; d++) begin
            if (dslm_pkg::DRV_W'(d) == r_in_drive) begin
                w_sel_head = r_head[d];
                w_sel_plat = r_plat[d];
                w_sel_zrun = r_zrun[d];
            end
        end
    end

    assign w_dist      = (r_in_cyl > w_sel_head) ? r_in_cyl - w_sel_head
                                                 : w_sel_head - r_in_cyl;
    assign w_dist_prod = dslm_pkg::DIST_PROD_W'(w_dist)
                       * dslm_pkg::DIST_PROD_W'(dslm_pkg::DIST_RECIP);
    assign w_gap_full  = (r_in_sec >= w_sel_plat)
                       ? 7'(r_in_sec) - 7'(w_sel_plat)
                       : 7'(r_in_sec) + 7'(dslm_pkg::SECTORS_PER_TRACK) - 7'(w_sel_plat);
    assign w_gap       = w_gap_full[dslm_pkg::SEC_W-1:0];
    assign w_gap_prod  = dslm_pkg::GAP_PROD_W'(w_gap)
                       * dslm_pkg::GAP_PROD_W'(dslm_pkg::GAP_RECIP);
    assign w_raw_ticks =
        dslm_pkg::RAW_TICK_W'(w_dist_prod[dslm_pkg::DIST_SHIFT +: dslm_pkg::DIST_Q_W])
      + ((r_in_cyl != w_sel_head) ? dslm_pkg::RAW_TICK_W'(dslm_pkg::CYL_CHANGE_COST)
                                  : '0)
      + dslm_pkg::RAW_TICK_W'(w_gap_prod[dslm_pkg::GAP_SHIFT +: dslm_pkg::GAP_Q_W]);
    assign w_sat_ticks = (w_raw_ticks > dslm_pkg::RAW_TICK_W'(dslm_pkg::TICK_MAX))
                       ? dslm_pkg::TICK_W'(dslm_pkg::TICK_MAX)
                       : w_raw_ticks[dslm_pkg::TICK_W-1:0];
    assign w_zrun_sum  = 7'(w_sel_zrun) + 7'(w_gap);

    always_comb begin
        w_ticks     = w_sat_ticks;
        w_zrun_next = '0;
        if (w_sat_ticks == '0) begin
            if (w_zrun_sum > 7'(dslm_pkg::ZERO_RUN_LIMIT)) begin
                w_ticks = dslm_pkg::TICK_W'(1);
            end else begin
                w_zrun_next = w_zrun_sum[dslm_pkg::ZRUN_W-1:0];
            end
        end
    end

    // per-drive next state and result
    logic [dslm_pkg::TICK_W-1:0]   w_res_ticks;
    logic [dslm_pkg::MASK_W-1:0]   w_done;
    logic [dslm_pkg::PHASES_W-1:0] w_phases;
    logic [dslm_pkg::MASK_W-1:0]   w_busy;
    logic [6:0]                    w_rot [NUM_DRIVES];

    always_comb begin
        w_res_ticks = '0;
        w_done      = '0;
        w_phases    = '0;
        w_busy      = '0;
        for (int d = 0; d < NUM_DRIVES; d++) begin
            n_head[d]   = r_head[d];
            n_plat[d]   = r_plat[d];
            n_rem[d]    = r_rem[d];
            n_seek[d]   = r_seek[d];
            n_spin[d]   = r_spin[d];
            n_zrun[d]   = r_zrun[d];
            n_tcyl[d]   = r_tcyl[d];
            n_tsec[d]   = r_tsec[d];
            n_pphase[d] = r_pphase[d];
            w_rot[d]    = 7'(r_plat[d]) + 7'(dslm_pkg::SECTORS_PER_TICK);
        end
        case (dslm_pkg::t_func'(r_in_func))
            dslm_pkg::FUNC_SEEK: begin
                if (w_drv_ok) begin
                    w_res_ticks = w_ticks;
                    for (int d = 0; d < NUM_DRIVES; d++) begin
                        if (dslm_pkg::DRV_W'(d) == r_in_drive) begin
                            n_seek[d]   = 1'b1;
                            n_rem[d]    = w_ticks;
                            n_zrun[d]   = w_zrun_next;
                            n_tcyl[d]   = r_in_cyl;
                            n_tsec[d]   = r_in_sec;
                            n_pphase[d] = r_in_phase;
                        end
                    end
                end
            end
            dslm_pkg::FUNC_TICK: begin
                for (int d = 0; d < NUM_DRIVES; d++) begin
                    if (r_present[d]) begin
                        if (r_seek[d] && r_rem[d] <= dslm_pkg::TICK_W'(1)) begin
                            n_seek[d] = 1'b0;
                            n_rem[d]  = '0;
                            n_plat[d] = r_tsec[d];
                            n_head[d] = r_tcyl[d];
                            w_done[d] = 1'b1;
                            w_phases[d*dslm_pkg::PHASE_W +: dslm_pkg::PHASE_W] = r_pphase[d];
                        end else if (r_rem[d] != '0) begin
                            n_rem[d] = r_rem[d] - dslm_pkg::TICK_W'(1);
                        end else if (r_spin[d]) begin
                            n_plat[d] = (w_rot[d] >= 7'(dslm_pkg::SECTORS_PER_TRACK))
                                ? dslm_pkg::SEC_W'(w_rot[d] - 7'(dslm_pkg::SECTORS_PER_TRACK))
                                : dslm_pkg::SEC_W'(w_rot[d]);
                        end
                    end
                end
            end
            dslm_pkg::FUNC_SPIN: begin
                for (int d = 0; d < NUM_DRIVES; d++) begin
                    if (w_drv_ok && dslm_pkg::DRV_W'(d) == r_in_drive) begin
                        n_spin[d] = r_in_spin;
                    end
                end
            end
            default: begin
            end
        endcase
        for (int d = 0; d < NUM_DRIVES; d++) begin
            w_busy[d] = n_seek[d];
        end
    end

    assign n_out_data = {{(dslm_pkg::OUT_TDATA_W - dslm_pkg::OUT_USED_W){1'b0}},
                         w_busy, w_phases, w_done, w_res_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < NUM_DRIVES; d++) begin
                r_head[d]   <= '0;
                r_plat[d]   <= '0;
                r_rem[d]    <= '0;
                r_seek[d]   <= 1'b0;
                r_spin[d]   <= 1'b0;
                r_zrun[d]   <= '0;
                r_tcyl[d]   <= '0;
                r_tsec[d]   <= '0;
                r_pphase[d] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_present <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                for (int d = 0; d < NUM_DRIVES; d++) begin
                    r_head[d]   <= n_head[d];
                    r_plat[d]   <= n_plat[d];
                    r_rem[d]    <= n_rem[d];
                    r_seek[d]   <= n_seek[d];
                    r_spin[d]   <= n_spin[d];
                    r_zrun[d]   <= n_zrun[d];
                    r_tcyl[d]   <= n_tcyl[d];
                    r_tsec[d]   <= n_tsec[d];
                    r_pphase[d] <= n_pphase[d];
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func  <= s_axis_tuser;
            r_in_drive <= s_axis_tdata[dslm_pkg::IN_DRIVE_LSB +: dslm_pkg::DRV_W];
            r_in_phase <= s_axis_tdata[dslm_pkg::IN_PHASE_LSB +: dslm_pkg::PHASE_W];
            r_in_spin  <= s_axis_tdata[dslm_pkg::IN_SPIN_LSB];
            r_in_cyl   <= w_s_cyl_prod[dslm_pkg::CYL_SHIFT +: dslm_pkg::CYL_W];
            r_in_sec   <= w_s_sec;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // a drive that completes on a tick is no longer busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        ((r_out_data[dslm_pkg::OUT_DONE_LSB +: dslm_pkg::MASK_W]
          & r_out_data[dslm_pkg::OUT_BUSY_LSB +: dslm_pkg::MASK_W]) == '0))
        else $error("completed drive still busy");

    // seek latency and completions never share one result
    a_seek_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[dslm_pkg::OUT_TICKS_LSB +: dslm_pkg::TICK_W] != '0) |->
        (r_out_data[dslm_pkg::OUT_DONE_LSB +: dslm_pkg::MASK_W] == '0))
        else $error("seek result carries completions");

    // a held request is not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_func)
                                        && $stable(r_in_drive)))
        else $error("stalled request lost");

    // a result leaves only when taken
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_out_valid) && $past(i_rst_n)) |-> $past(m_axis_tready))
        else $error("result dropped without handshake");
`endif

endmodule
